>>> rtl/sne_pkg.sv
// ----------------------------------------------------------------------------
// sne_pkg
// Shared constants for the stereo note envelope: default widths, fixed-point
// formats, register map, command codes and register reset values.
// ----------------------------------------------------------------------------
package sne_pkg;

  // default widths
  localparam int DEF_COUNT_BITS  = 20;
  localparam int DEF_SAMPLE_BITS = 16;

  // fixed-point formats
  localparam int FRAC_BITS  = 16;  // quotient fraction bits
  localparam int GAIN_BITS  = 16;  // Q2.14 gain word
  localparam int GAIN_FRAC  = 14;
  localparam int FADE_SHIFT = FRAC_BITS + GAIN_FRAC;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_ATTACK   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DECAY    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_NOTE     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FADE_IN  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FADE_OUT = 3'd5;

  // register reset values
  localparam int ATTACK_RST   = 2205;
  localparam int DECAY_RST    = 44100;
  localparam int RELEASE_RST  = 2205;
  localparam int NOTE_RST     = 4410;
  localparam int FADE_IN_RST  = 16384;
  localparam int FADE_OUT_RST = 16384;

  // input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_START  = 1'b1;

endpackage

>>> rtl/sne_div.sv
// ----------------------------------------------------------------------------
// sne_div
// Bit-serial restoring divider: one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module sne_div
  import sne_pkg::*;
#(
  parameter int NUM_W = DEF_COUNT_BITS + FRAC_BITS,
  parameter int DEN_W = DEF_COUNT_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(NUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_reg;
  logic [NUM_W-1:0]  quo_sh;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    diff;
  logic              take;

  assign rem_sh = {rem, quo_sh[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_reg};
  assign take   = ~diff[DEN_W];
  assign quo    = quo_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        step    <= '0;
        rem     <= '0;
        quo_sh  <= num;
        den_reg <= den;
      end else if (busy) begin
        // shift dividend out the top, quotient bits in at the bottom
        quo_sh <= {quo_sh[NUM_W-2:0], take};
        rem    <= take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        step   <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/sne_mul.sv
// ----------------------------------------------------------------------------
// sne_mul
// Shared signed-by-unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module sne_mul
  import sne_pkg::*;
#(
  parameter int A_W = DEF_SAMPLE_BITS + 1,
  parameter int B_W = DEF_SAMPLE_BITS + FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [A_W-1:0]       a,
  input  logic        [B_W-1:0]       b,
  output logic signed [A_W+B_W-1:0]   prod
);

  logic signed [A_W+B_W:0] full;

  assign full = a * $signed({1'b0, b});

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full[A_W+B_W-1:0];
    end
  end

endmodule

>>> rtl/stereo_note_envelope.sv
// ----------------------------------------------------------------------------
// stereo_note_envelope
// Note envelope on a stereo sample stream: attack, decay, release and
// pass-through phases chosen from a sample counter, with saturating output.
// ----------------------------------------------------------------------------
// A start word clears the sample counter. A sample word in the pass-through
// phase, or in release past the note end, goes from idle straight to the done
// state. A sample word in attack or release runs through the divide, gain,
// left, right and right-saturate states; one in decay skips the gain state
// since it needs no gain product: the gain quotient comes from a bit-serial
// divider that produces one bit per cycle over COUNT_BITS+16 bits, then one
// shared multiplier forms gain times quotient and the left and right products
// in turn. The input side is held off while a word is in work; the result sits
// in an output register, so the next word is taken while it waits.
// ----------------------------------------------------------------------------
module stereo_note_envelope
  import sne_pkg::*;
#(
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_W-1:0]         paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready,
  // source channel
  input  logic                          src_valid,
  output logic                          src_ready,
  input  logic                          cmd,
  input  logic signed [SAMPLE_BITS-1:0] src_left,
  input  logic signed [SAMPLE_BITS-1:0] src_right,
  // result channel
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic                          active
);

  localparam int CNT_W  = COUNT_BITS + 1;
  localparam int SW     = COUNT_BITS + 3;
  localparam int NUM_W  = COUNT_BITS + FRAC_BITS;
  localparam int MA     = (SAMPLE_BITS > GAIN_BITS + 1) ? SAMPLE_BITS : GAIN_BITS + 1;
  localparam int MB     = (SAMPLE_BITS + 16 > 32) ? SAMPLE_BITS + 16 : 32;
  localparam int PW     = MA + MB;
  localparam int CW     = (NUM_W > SAMPLE_BITS + 16) ? NUM_W : SAMPLE_BITS + 16;

  localparam logic [CW-1:0]        Q_CAP    = CW'(1) << (SAMPLE_BITS + 15);
  localparam logic signed [PW-1:0] SMP_MAX  = (PW'(1) << (SAMPLE_BITS - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SMP_MIN  = ~SMP_MAX;
  localparam logic signed [PW-1:0] RND_FADE = (PW'(1) << FADE_SHIFT) - PW'(1);
  localparam logic signed [PW-1:0] RND_FRAC = (PW'(1) << FRAC_BITS) - PW'(1);
  localparam logic [CNT_W-1:0]     CNT_MAX  = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL_G,
    S_MUL_L,
    S_MUL_R,
    S_SAT_R,
    S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [COUNT_BITS-1:0] attack_len;
  logic [COUNT_BITS-1:0] decay_len;
  logic [COUNT_BITS-1:0] release_len;
  logic [COUNT_BITS-1:0] note_len;
  logic [GAIN_BITS-1:0]  fade_in_gain;
  logic [GAIN_BITS-1:0]  fade_out_gain;

  // work registers
  logic [CNT_W-1:0]              sample_count;
  logic signed [SAMPLE_BITS-1:0] left_smp;
  logic signed [SAMPLE_BITS-1:0] right_smp;
  logic                          faded;
  logic [GAIN_BITS-1:0]          gain;
  logic [MB-1:0]                 q_val;
  logic signed [SAMPLE_BITS-1:0] res_left;
  logic signed [SAMPLE_BITS-1:0] res_right;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_ATTACK:   prdata = APB_DATA_W'(attack_len);
      REG_DECAY:    prdata = APB_DATA_W'(decay_len);
      REG_RELEASE:  prdata = APB_DATA_W'(release_len);
      REG_NOTE:     prdata = APB_DATA_W'(note_len);
      REG_FADE_IN:  prdata = APB_DATA_W'(fade_in_gain);
      REG_FADE_OUT: prdata = APB_DATA_W'(fade_out_gain);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len    <= COUNT_BITS'(ATTACK_RST);
      decay_len     <= COUNT_BITS'(DECAY_RST);
      release_len   <= COUNT_BITS'(RELEASE_RST);
      note_len      <= COUNT_BITS'(NOTE_RST);
      fade_in_gain  <= GAIN_BITS'(FADE_IN_RST);
      fade_out_gain <= GAIN_BITS'(FADE_OUT_RST);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ATTACK:   attack_len    <= pwdata[COUNT_BITS-1:0];
        REG_DECAY:    decay_len     <= pwdata[COUNT_BITS-1:0];
        REG_RELEASE:  release_len   <= pwdata[COUNT_BITS-1:0];
        REG_NOTE:     note_len      <= pwdata[COUNT_BITS-1:0];
        REG_FADE_IN:  fade_in_gain  <= pwdata[GAIN_BITS-1:0];
        REG_FADE_OUT: fade_out_gain <= pwdata[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // phase selection from the current count
  logic signed [SW-1:0]  cnt_s;
  logic signed [SW-1:0]  note_s;
  logic signed [SW-1:0]  rel_start;
  logic signed [SW-1:0]  remain;
  logic                  in_attack;
  logic                  in_decay;
  logic                  in_release;
  logic                  rel_zero;
  logic                  src_take;
  logic                  div_start;
  logic [COUNT_BITS-1:0] div_n;
  logic [COUNT_BITS-1:0] div_den;
  logic                  div_done;
  logic [NUM_W-1:0]      div_quo;
  logic [CW-1:0]         quo_ext;
  logic [CW-1:0]         q_capped;

  assign cnt_s      = $signed(SW'(sample_count));
  assign note_s     = $signed(SW'(note_len));
  assign rel_start  = note_s - $signed(SW'(release_len));
  assign remain     = note_s - cnt_s;
  assign in_attack  = sample_count < CNT_W'(attack_len);
  assign in_decay   = (sample_count > CNT_W'(attack_len)) &&
                      (sample_count < CNT_W'(decay_len)) && (cnt_s < rel_start);
  assign in_release = cnt_s > rel_start;
  assign rel_zero   = (remain <= $signed(SW'(0))) || (release_len == '0);

  assign src_ready  = (state == S_IDLE);
  assign src_take   = src_valid & src_ready;

  always_comb begin
    div_n   = remain[COUNT_BITS-1:0];
    div_den = release_len;
    if (in_attack) begin
      div_n   = sample_count[COUNT_BITS-1:0];
      div_den = attack_len;
    end else if (in_decay) begin
      div_den = decay_len;
    end
  end

  assign div_start = src_take && (cmd == CMD_SAMPLE) &&
                     (in_attack || in_decay || (in_release && !rel_zero));

  sne_div #(
    .NUM_W (NUM_W),
    .DEN_W (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({div_n, {FRAC_BITS{1'b0}}}),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign quo_ext  = CW'(div_quo);
  assign q_capped = (quo_ext > Q_CAP) ? Q_CAP : quo_ext;

  // shared multiplier operand select
  logic                 mul_en;
  logic signed [MA-1:0] mul_a;
  logic [MB-1:0]        mul_b;
  logic signed [PW-1:0] prod;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = MA'(left_smp);
    mul_b  = q_val;
    case (state)
      S_MUL_G: begin
        mul_en = 1'b1;
        mul_a  = $signed(MA'(gain));
      end
      S_MUL_L: begin
        mul_en = 1'b1;
        mul_b  = faded ? prod[MB-1:0] : q_val;
      end
      S_MUL_R: begin
        mul_en = 1'b1;
        mul_a  = MA'(right_smp);
      end
      default: ;
    endcase
  end

  sne_mul #(
    .A_W (MA),
    .B_W (MB)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // scale down toward zero, then saturate to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] scale_sat(
    input logic signed [PW-1:0] p,
    input logic                 fade
  );
    logic signed [PW-1:0] biased;
    logic signed [PW-1:0] shifted;
    biased  = p + ((p < 0) ? (fade ? RND_FADE : RND_FRAC) : '0);
    shifted = fade ? (biased >>> FADE_SHIFT) : (biased >>> FRAC_BITS);
    if (shifted > SMP_MAX) begin
      shifted = SMP_MAX;
    end else if (shifted < SMP_MIN) begin
      shifted = SMP_MIN;
    end
    return shifted[SAMPLE_BITS-1:0];
  endfunction

  logic [CNT_W-1:0] cnt_inc;
  logic             out_load;

  assign cnt_inc  = (sample_count == CNT_MAX) ? sample_count : sample_count + 1'b1;
  assign out_load = (state == S_DONE) && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_count <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (res_valid && res_ready && !out_load) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (src_take) begin
            left_smp  <= src_left;
            right_smp <= src_right;
            if (cmd == CMD_START) begin
              sample_count <= '0;
            end else if (in_attack) begin
              faded <= 1'b1;
              gain  <= fade_in_gain;
              state <= S_DIV;
            end else if (in_decay) begin
              faded <= 1'b0;
              state <= S_DIV;
            end else if (in_release) begin
              faded <= 1'b1;
              gain  <= fade_out_gain;
              if (rel_zero) begin
                res_left  <= '0;
                res_right <= '0;
                state     <= S_DONE;
              end else begin
                state <= S_DIV;
              end
            end else begin
              res_left  <= src_left;
              res_right <= src_right;
              state     <= S_DONE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            q_val <= MB'(q_capped);
            state <= faded ? S_MUL_G : S_MUL_L;
          end
        end
        S_MUL_G: begin
          state <= S_MUL_L;
        end
        S_MUL_L: begin
          // keep the effective gain for the right channel
          q_val <= mul_b;
          state <= S_MUL_R;
        end
        S_MUL_R: begin
          res_left <= scale_sat(prod, faded);
          state    <= S_SAT_R;
        end
        S_SAT_R: begin
          res_right <= scale_sat(prod, faded);
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_left     <= res_left;
            out_right    <= res_right;
            active       <= cnt_inc < CNT_W'(note_len);
            sample_count <= cnt_inc;
            res_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stereo_note_envelope. A directed table covers reset
// values, the gain extremes, zero attack and release lengths, the capped decay
// quotient and the counter running past note end. Randomized note sequences
// follow under changing register settings; both handshake sides idle at random.
// Results are held to a row's fixed value or to a local envelope predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sne_pkg::*;

  localparam int     CW            = DEF_COUNT_BITS;
  localparam int     SW            = DEF_SAMPLE_BITS;
  localparam int     WORD_TARGET   = 1800;
  localparam int     GAP_MAX       = 16;
  localparam int     SETTLE_CYCLES = 64;
  localparam longint CYCLE_LIMIT   = 3_000_000;
  localparam longint QUOT_CAP      = longint'(1) << (SW + 15);

  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 active;
  } env_result_t;

  typedef struct {
    bit                    is_cfg;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [APB_DATA_W-1:0] reg_val;
    logic                  cmd;
    logic signed [SW-1:0]  left;
    logic signed [SW-1:0]  right;
    bit                    typed;
    env_result_t           want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  src_valid;
  logic                  src_ready;
  logic                  cmd;
  logic signed [SW-1:0]  src_left;
  logic signed [SW-1:0]  src_right;
  logic                  res_valid;
  logic                  res_ready;
  logic signed [SW-1:0]  out_left;
  logic signed [SW-1:0]  out_right;
  logic                  active;

  // envelope predictor state
  logic [CW-1:0]        attack_len;
  logic [CW-1:0]        decay_len;
  logic [CW-1:0]        release_len;
  logic [CW-1:0]        note_len;
  logic [GAIN_BITS-1:0] fade_in_gain;
  logic [GAIN_BITS-1:0] fade_out_gain;
  logic [CW:0]          sample_count;

  env_result_t pending_results[$];
  int          errors        = 0;
  int          words_sent    = 0;
  int          results_seen  = 0;
  int          src_gap_max   = GAP_MAX;
  int          snk_stall_max = GAP_MAX;
  longint      cycles        = 0;

  stereo_note_envelope i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .cmd       (cmd),
    .src_left  (src_left),
    .src_right (src_right),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_left  (out_left),
    .out_right (out_right),
    .active    (active)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("stereo_note_envelope regression: fail");
      $finish;
    end
  end

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function automatic logic signed [SW-1:0] clip_sample(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (SW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] fade_scale(longint s, longint q, longint gain);
    return clip_sample((s * q * gain) / (longint'(1) << FADE_SHIFT));
  endfunction

  function automatic logic signed [SW-1:0] plain_scale(longint s, longint q);
    return clip_sample((s * q) / (longint'(1) << FRAC_BITS));
  endfunction

  // returns 1 when the word produces a result
  function automatic bit envelope_step(input logic c, input logic signed [SW-1:0] l,
                                       input logic signed [SW-1:0] r,
                                       output env_result_t res);
    longint cnt;
    longint att;
    longint dcy;
    longint rel;
    longint nte;
    longint rem;
    longint q;
    res = '0;
    if (c == CMD_START) begin
      sample_count = '0;
      return 1'b0;
    end
    cnt = longint'(sample_count);
    att = longint'(attack_len);
    dcy = longint'(decay_len);
    rel = longint'(release_len);
    nte = longint'(note_len);
    if (cnt < att) begin
      q = (cnt << FRAC_BITS) / att;
      res.left  = fade_scale(l, q, longint'(fade_in_gain));
      res.right = fade_scale(r, q, longint'(fade_in_gain));
    end else if (cnt > att && cnt < dcy && cnt < nte - rel) begin
      q = ((nte - cnt) << FRAC_BITS) / dcy;
      if (q > QUOT_CAP) q = QUOT_CAP;
      res.left  = plain_scale(l, q);
      res.right = plain_scale(r, q);
    end else if (cnt > nte - rel) begin
      rem = nte - cnt;
      // past note end or zero release length: gain is zero
      q = (rem <= 0 || rel == 0) ? 0 : (rem << FRAC_BITS) / rel;
      res.left  = fade_scale(l, q, longint'(fade_out_gain));
      res.right = fade_scale(r, q, longint'(fade_out_gain));
    end else begin
      res.left  = l;
      res.right = r;
    end
    if (sample_count != '1) sample_count++;
    res.active = (sample_count < note_len);
    return 1'b1;
  endfunction

  function automatic void apply_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
    case (idx)
      REG_ATTACK:   attack_len    = val[CW-1:0];
      REG_DECAY:    decay_len     = val[CW-1:0];
      REG_RELEASE:  release_len   = val[CW-1:0];
      REG_NOTE:     note_len      = val[CW-1:0];
      REG_FADE_IN:  fade_in_gain  = val[GAIN_BITS-1:0];
      REG_FADE_OUT: fade_out_gain = val[GAIN_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [APB_DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_ATTACK:   return APB_DATA_W'(attack_len);
      REG_DECAY:    return APB_DATA_W'(decay_len);
      REG_RELEASE:  return APB_DATA_W'(release_len);
      REG_NOTE:     return APB_DATA_W'(note_len);
      REG_FADE_IN:  return APB_DATA_W'(fade_in_gain);
      REG_FADE_OUT: return APB_DATA_W'(fade_out_gain);
      default:      return '0;
    endcase
  endfunction

  function automatic plan_row_t cfg_row(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic plan_row_t word_row(logic c, logic signed [SW-1:0] l,
                                         logic signed [SW-1:0] r);
    plan_row_t row;
    row = '{default: '0};
    row.cmd   = c;
    row.left  = l;
    row.right = r;
    return row;
  endfunction

  function automatic plan_row_t known_row(logic signed [SW-1:0] l, logic signed [SW-1:0] r,
                                          logic signed [SW-1:0] el, logic signed [SW-1:0] er,
                                          logic ea);
    plan_row_t row;
    row = word_row(CMD_SAMPLE, l, r);
    row.typed = 1'b1;
    row.want  = '{left: el, right: er, active: ea};
    return row;
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return SW'($urandom_range(0, 15)) - 16'sd8;
      default: return SW'($urandom());
    endcase
  endfunction

  function automatic logic [APB_DATA_W-1:0] pick_len(int span);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return APB_DATA_W'({CW{1'b1}});
      2:       return $urandom_range(0, (1 << CW) - 1);
      default: return $urandom_range(1, span);
    endcase
  endfunction

  function automatic logic [APB_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return APB_DATA_W'({GAIN_BITS{1'b1}});
      2:       return FADE_IN_RST;
      default: return $urandom_range(0, (1 << GAIN_BITS) - 1);
    endcase
  endfunction

  task automatic reg_check(input logic [REG_IDX_W-1:0] idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_value(idx))
      flag_error($sformatf("register %0d read: expected 0x%0h, got 0x%0h",
                           idx, reg_value(idx), prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx <= REG_FADE_OUT) reg_check(idx);
  endtask

  task automatic send_word(input logic c, input logic signed [SW-1:0] l,
                           input logic signed [SW-1:0] r, input bit typed,
                           input env_result_t want);
    int          gap;
    env_result_t pred;
    gap = $urandom_range(0, src_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_valid <= 1'b1;
    cmd       <= c;
    src_left  <= l;
    src_right <= r;
    do @(posedge clk); while (!src_ready);
    if (envelope_step(c, l, r, pred)) pending_results.push_back(typed ? want : pred);
    words_sent++;
  endtask

  // drop valid, wait for every result, then let a trailing start word finish
  task automatic settle();
    @(negedge clk);
    src_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int          stall;
    env_result_t want;
    res_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = $urandom_range(0, snk_stall_max);
      @(negedge clk);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result %0d with nothing pending: L=%0d R=%0d active=%0b",
                             results_seen, out_left, out_right, active));
      end else begin
        want = pending_results.pop_front();
        if (out_left !== want.left || out_right !== want.right || active !== want.active)
          flag_error($sformatf({"result %0d: expected L=%0d R=%0d active=%0b, ",
                                "got L=%0d R=%0d active=%0b"}, results_seen,
                               want.left, want.right, want.active,
                               out_left, out_right, active));
      end
    end
  end

  initial begin : stimulus
    plan_row_t   plan[$];
    env_result_t no_want;
    bit          quiet;
    int          seq_len;
    logic        c;
    no_want   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    src_valid = 1'b0;
    cmd       = CMD_SAMPLE;
    src_left  = '0;
    src_right = '0;
    attack_len    = ATTACK_RST;
    decay_len     = DECAY_RST;
    release_len   = RELEASE_RST;
    note_len      = NOTE_RST;
    fade_in_gain  = FADE_IN_RST;
    fade_out_gain = FADE_OUT_RST;
    sample_count  = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = REG_ATTACK; i <= REG_FADE_OUT; i++) reg_check(REG_IDX_W'(i));

    plan = '{
      // reset settings: count zero sits in attack with zero gain
      known_row(16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, 1'b1),
      word_row(CMD_START, 16'sh5a5a, 16'sh1234),
      known_row(-16'sd1, 16'sd1, 16'sd0, 16'sd0, 1'b1),
      // no attack, tiny decay divisor, longest note, no release
      cfg_row(REG_ATTACK, 32'd0),
      cfg_row(REG_DECAY, 32'd2),
      cfg_row(REG_RELEASE, 32'd0),
      cfg_row(REG_NOTE, 32'h000f_ffff),
      cfg_row(REG_FADE_IN, 32'h0000_ffff),
      cfg_row(REG_FADE_OUT, 32'd0),
      cfg_row(REG_UNMAPPED_LO, 32'hffff_ffff),
      cfg_row(REG_UNMAPPED_HI, 32'h0000_0001),
      word_row(CMD_START, -16'sd1, 16'sh7fff),
      known_row(16'sd12345, -16'sd23456, 16'sd12345, -16'sd23456, 1'b1),
      // capped decay quotient saturates both channels
      known_row(16'sd100, -16'sd100, 16'sh7fff, 16'sh8000, 1'b1),
      known_row(16'sd0, 16'sd1, 16'sd0, 16'sd1, 1'b1),
      // shorten the note under the counter: pass once, then past note end
      cfg_row(REG_NOTE, 32'd3),
      known_row(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0),
      known_row(16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, 1'b0),
      // short note walking every phase
      cfg_row(REG_ATTACK, 32'd4),
      cfg_row(REG_DECAY, 32'd10),
      cfg_row(REG_RELEASE, 32'd4),
      cfg_row(REG_NOTE, 32'd12),
      cfg_row(REG_FADE_IN, 32'h0000_c000),
      cfg_row(REG_FADE_OUT, 32'h0000_ffff),
      word_row(CMD_START, 16'sh0f0f, 16'shf0f0),
      word_row(CMD_SAMPLE, 16'sh7fff, 16'sh8000),
      word_row(CMD_SAMPLE, 16'sh7fff, 16'sh8000),
      word_row(CMD_SAMPLE, 16'sh8000, 16'sh7fff),
      word_row(CMD_SAMPLE, 16'sh5555, 16'shaaaa),
      word_row(CMD_SAMPLE, 16'shaaaa, 16'sh5555),
      word_row(CMD_SAMPLE, 16'sh7fff, 16'sh8000),
      word_row(CMD_SAMPLE, 16'sh8000, 16'sh7fff),
      word_row(CMD_SAMPLE, -16'sd1, 16'sd1),
      word_row(CMD_SAMPLE, 16'sh4000, -16'sh4000),
      word_row(CMD_SAMPLE, 16'sh7fff, 16'sh8000),
      word_row(CMD_SAMPLE, 16'sh8000, 16'sh7fff),
      word_row(CMD_SAMPLE, 16'sh7fff, 16'sh8000),
      word_row(CMD_SAMPLE, 16'sh7fff, 16'sh8000),
      word_row(CMD_SAMPLE, 16'sh1234, -16'sh1234),
      word_row(CMD_SAMPLE, 16'sh7fff, 16'sh8000)
    };

    quiet = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!quiet) settle();
        quiet = 1'b1;
        apb_write(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        quiet = 1'b0;
        send_word(plan[i].cmd, plan[i].left, plan[i].right, plan[i].typed, plan[i].want);
      end
    end

    while (words_sent < WORD_TARGET) begin
      settle();
      apb_write(REG_ATTACK, pick_len(40));
      apb_write(REG_DECAY, pick_len(120));
      apb_write(REG_RELEASE, pick_len(40));
      apb_write(REG_NOTE, pick_len(120));
      apb_write(REG_FADE_IN, pick_gain());
      apb_write(REG_FADE_OUT, pick_gain());
      if ($urandom_range(0, 7) == 0)
        apb_write($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, $urandom());
      src_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      snk_stall_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      if ($urandom_range(0, 9) == 0) begin
        // noise: commands in any order
        repeat ($urandom_range(5, 40))
          send_word(1'($urandom_range(0, 1)), rand_sample(), rand_sample(), 1'b0, no_want);
      end else begin
        send_word(CMD_START, rand_sample(), rand_sample(), 1'b0, no_want);
        seq_len = int'(note_len) + $urandom_range(0, 8);
        if (seq_len > 150) seq_len = $urandom_range(60, 150);
        for (int k = 0; k < seq_len; k++) begin
          // restart mid-note now and then
          c = ($urandom_range(0, 59) == 0) ? CMD_START : CMD_SAMPLE;
          send_word(c, rand_sample(), rand_sample(), 1'b0, no_want);
        end
      end
    end

    settle();
    if (errors == 0) $display("stereo_note_envelope regression: pass");
    else $display("stereo_note_envelope regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
rtl/sne_pkg.sv
rtl/sne_div.sv
rtl/sne_mul.sv
rtl/stereo_note_envelope.sv
verif/testbench.sv
